[src/pidr_pkg.sv]
// ----------------------------------------------------------------------------
// pidr_pkg
// Types, lane-width codes and per-stage arithmetic for the packed integer
// divider with remainder.
// ----------------------------------------------------------------------------
package pidr_pkg;

  // Lane width codes, taken from operation[2:1].
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  // Number of divide steps; one step is done per pipeline stage.
  localparam int NUM_STEPS = 64;

  // Operation codes.
  localparam logic [2:0] OP_U8  = 3'd0;
  localparam logic [2:0] OP_S8  = 3'd1;
  localparam logic [2:0] OP_U16 = 3'd2;
  localparam logic [2:0] OP_S16 = 3'd3;
  localparam logic [2:0] OP_U32 = 3'd4;
  localparam logic [2:0] OP_S32 = 3'd5;
  localparam logic [2:0] OP_U64 = 3'd6;
  localparam logic [2:0] OP_S64 = 3'd7;

  // State of one 64-bit word in flight. The dividend magnitude is shifted out
  // of a from the top of each lane while quotient bits enter at the bottom.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] rem;
    logic [63:0] y;
    logic [7:0]  nq;  // negate the lane quotient at the end
    logic [7:0]  nr;  // negate the lane remainder at the end
    logic [7:0]  dz;  // lane divisor is zero
  } word_t;

  typedef struct packed {
    word_t      lo;
    word_t      hi;
    logic [2:0] op;
  } stage_t;

  // Take the magnitudes of every lane and record the sign handling.
  function automatic word_t prep(input logic [63:0] x, input logic [63:0] y,
                                 input logic [2:0] op);
    word_t w;
    logic  sx;
    logic  sy;
    w = '0;
    case (op[2:1])
      WIDTH_8: begin
        for (int i = 0; i < 8; i++) begin
          sx = op[0] & x[i*8+7];
          sy = op[0] & y[i*8+7];
          w.a[i*8 +: 8] = sx ? -x[i*8 +: 8] : x[i*8 +: 8];
          w.y[i*8 +: 8] = sy ? -y[i*8 +: 8] : y[i*8 +: 8];
          w.nq[i] = sx ^ sy;
          w.nr[i] = sx;
          w.dz[i] = (y[i*8 +: 8] == 8'd0);
        end
      end
      WIDTH_16: begin
        for (int i = 0; i < 4; i++) begin
          sx = op[0] & x[i*16+15];
          sy = op[0] & y[i*16+15];
          w.a[i*16 +: 16] = sx ? -x[i*16 +: 16] : x[i*16 +: 16];
          w.y[i*16 +: 16] = sy ? -y[i*16 +: 16] : y[i*16 +: 16];
          w.nq[i] = sx ^ sy;
          w.nr[i] = sx;
          w.dz[i] = (y[i*16 +: 16] == 16'd0);
        end
      end
      WIDTH_32: begin
        for (int i = 0; i < 2; i++) begin
          sx = op[0] & x[i*32+31];
          sy = op[0] & y[i*32+31];
          w.a[i*32 +: 32] = sx ? -x[i*32 +: 32] : x[i*32 +: 32];
          w.y[i*32 +: 32] = sy ? -y[i*32 +: 32] : y[i*32 +: 32];
          w.nq[i] = sx ^ sy;
          w.nr[i] = sx;
          w.dz[i] = (y[i*32 +: 32] == 32'd0);
        end
      end
      default: begin
        sx = op[0] & x[63];
        sy = op[0] & y[63];
        w.a = sx ? -x : x;
        w.y = sy ? -y : y;
        w.nq[0] = sx ^ sy;
        w.nr[0] = sx;
        w.dz[0] = (y == 64'd0);
      end
    endcase
    return w;
  endfunction

  // One restoring divide step for every lane. Step k is active for a lane of
  // width w only when k >= 64 - w, so every lane finishes after 64 steps.
  function automatic word_t step(input word_t s, input logic [1:0] ws, input int k);
    word_t       o;
    logic [8:0]  t9;
    logic [16:0] t17;
    logic [32:0] t33;
    logic [64:0] t65;
    logic        qb;
    o = s;
    case (ws)
      WIDTH_8: begin
        if (k >= 56) begin
          for (int i = 0; i < 8; i++) begin
            t9 = {s.rem[i*8 +: 8], s.a[i*8+7]};
            qb = (t9 >= {1'b0, s.y[i*8 +: 8]});
            if (qb) t9 = t9 - {1'b0, s.y[i*8 +: 8]};
            o.rem[i*8 +: 8] = t9[7:0];
            o.a[i*8 +: 8] = {s.a[i*8 +: 7], qb};
          end
        end
      end
      WIDTH_16: begin
        if (k >= 48) begin
          for (int i = 0; i < 4; i++) begin
            t17 = {s.rem[i*16 +: 16], s.a[i*16+15]};
            qb = (t17 >= {1'b0, s.y[i*16 +: 16]});
            if (qb) t17 = t17 - {1'b0, s.y[i*16 +: 16]};
            o.rem[i*16 +: 16] = t17[15:0];
            o.a[i*16 +: 16] = {s.a[i*16 +: 15], qb};
          end
        end
      end
      WIDTH_32: begin
        if (k >= 32) begin
          for (int i = 0; i < 2; i++) begin
            t33 = {s.rem[i*32 +: 32], s.a[i*32+31]};
            qb = (t33 >= {1'b0, s.y[i*32 +: 32]});
            if (qb) t33 = t33 - {1'b0, s.y[i*32 +: 32]};
            o.rem[i*32 +: 32] = t33[31:0];
            o.a[i*32 +: 32] = {s.a[i*32 +: 31], qb};
          end
        end
      end
      default: begin
        t65 = {s.rem, s.a[63]};
        qb = (t65 >= {1'b0, s.y});
        if (qb) t65 = t65 - {1'b0, s.y};
        o.rem = t65[63:0];
        o.a = {s.a[62:0], qb};
      end
    endcase
    return o;
  endfunction

  // Restore signs and apply the zero-divisor rule. With a zero divisor the
  // remainder path already holds the dividend, so only the quotient changes.
  function automatic logic [127:0] finish(input word_t s, input logic [1:0] ws);
    logic [63:0] q;
    logic [63:0] r;
    case (ws)
      WIDTH_8: begin
        for (int i = 0; i < 8; i++) begin
          q[i*8 +: 8] = s.dz[i] ? 8'hff : (s.nq[i] ? -s.a[i*8 +: 8] : s.a[i*8 +: 8]);
          r[i*8 +: 8] = s.nr[i] ? -s.rem[i*8 +: 8] : s.rem[i*8 +: 8];
        end
      end
      WIDTH_16: begin
        for (int i = 0; i < 4; i++) begin
          q[i*16 +: 16] = s.dz[i] ? 16'hffff
                                  : (s.nq[i] ? -s.a[i*16 +: 16] : s.a[i*16 +: 16]);
          r[i*16 +: 16] = s.nr[i] ? -s.rem[i*16 +: 16] : s.rem[i*16 +: 16];
        end
      end
      WIDTH_32: begin
        for (int i = 0; i < 2; i++) begin
          q[i*32 +: 32] = s.dz[i] ? 32'hffff_ffff
                                  : (s.nq[i] ? -s.a[i*32 +: 32] : s.a[i*32 +: 32]);
          r[i*32 +: 32] = s.nr[i] ? -s.rem[i*32 +: 32] : s.rem[i*32 +: 32];
        end
      end
      default: begin
        q = s.dz[0] ? '1 : (s.nq[0] ? -s.a : s.a);
        r = s.nr[0] ? -s.rem : s.rem;
      end
    endcase
    return {q, r};
  endfunction

endpackage

[src/packed_integer_divide_remainder.sv]
// ----------------------------------------------------------------------------
// packed_integer_divide_remainder
// Lane-wise integer divide with remainder on 128-bit packed vectors.
// ----------------------------------------------------------------------------
// A transaction is accepted on every clock edge where start is high; busy is
// always low, so a new vector may be issued in every cycle. The result of a
// transaction appears on the quotient and remainder ports from the output
// register, held for exactly one cycle and marked by done. The receiver
// cannot stall the pipe, so it must capture each result in the cycle in which
// done is high. The pipe is built as a restoring divider: one quotient bit
// per pipeline stage over 64 stages, plus one stage that takes operand
// magnitudes up front; the sign fix-up and output register close the pipe.
// Narrow lanes pass through the early stages untouched and are worked on only
// in the last w stages, so every lane width has the same latency.
// Each lane gives the quotient truncated toward zero and a remainder with the
// sign of the dividend. A zero divisor gives an all-ones quotient and returns
// the dividend as remainder; the signed minimum divided by minus one wraps to
// the minimum with a zero remainder.
module packed_integer_divide_remainder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [63:0] dividend_low,
  input  logic [63:0] dividend_high,
  input  logic [63:0] divisor_low,
  input  logic [63:0] divisor_high,
  output logic        done,
  output logic [63:0] quotient_low,
  output logic [63:0] quotient_high,
  output logic [63:0] remainder_low,
  output logic [63:0] remainder_high
);
  import pidr_pkg::*;

  // Stage 0 holds the prepared operands; stage k+1 holds the result of
  // divide step k.
  stage_t             pipe [0:NUM_STEPS];
  logic [NUM_STEPS:0] vld;

  logic [127:0] fin_lo;
  logic [127:0] fin_hi;

  // The pipe never stalls, so the block is never busy.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    pipe[0].lo <= prep(dividend_low, divisor_low, operation);
    pipe[0].hi <= prep(dividend_high, divisor_high, operation);
    pipe[0].op <= operation;
  end

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      pipe[k+1].lo <= step(pipe[k].lo, pipe[k].op[2:1], k);
      pipe[k+1].hi <= step(pipe[k].hi, pipe[k].op[2:1], k);
      pipe[k+1].op <= pipe[k].op;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[NUM_STEPS-1:0], start};
      done <= vld[NUM_STEPS];
    end
  end

  assign fin_lo = finish(pipe[NUM_STEPS].lo, pipe[NUM_STEPS].op[2:1]);
  assign fin_hi = finish(pipe[NUM_STEPS].hi, pipe[NUM_STEPS].op[2:1]);

  always_ff @(posedge clk) begin
    quotient_low   <= fin_lo[127:64];
    remainder_low  <= fin_lo[63:0];
    quotient_high  <= fin_hi[127:64];
    remainder_high <= fin_hi[63:0];
  end

endmodule
